>>> sv/variable_partition_allocator_unit_assert.svh
// Assertion helpers for the allocator
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
// property holds in every cycle out of reset
`define VPA_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// cause implies effect in the next cycle
`define VPA_NEXT(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);
`endif

>>> sv/vpa_pkg.sv
package vpa_pkg;
	localparam int MaxEntries = 16;
	localparam int AddrBits   = 16;
	localparam int IdxW       = $clog2(MaxEntries);
	localparam int CntW       = IdxW + 1;
	localparam int SizeW      = AddrBits + 1;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_REBUILD = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_BAD_BASE = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;
	localparam logic [1:0] FIT_WORST = 2'd3;

	localparam logic [1:0] REG_FIT_MODE = 2'd0;
	localparam logic [1:0] REG_COMPACT  = 2'd1;
	localparam logic [1:0] REG_INIT_CNT = 2'd2;
	localparam logic [1:0] REG_INIT_SZ  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_CMP, S_CMPF, S_SINIT, S_SCAN, S_SPLIT,
		S_RSCAN, S_R1, S_R2, S_R3, S_REB, S_DONE
	} state_t;
endpackage

>>> sv/variable_partition_allocator_unit.sv
// Variable partition allocator.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the action
// (allocate, release, rebuild), s_tdata the request size and release base.
// Each word gives exactly one result word on m_tvalid/m_tready: status in
// m_tuser, granted base in m_tdata.
// Configuration (fit mode, compaction, rebuild count and size) is written on
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, and the block does not enforce this. One table entry is visited per
// cycle by a single sequencer with one read port onto the table. Allocate
// compacts first if enabled, scans and splits; release scans for the base and
// merges free neighbours; rebuild writes up to min(initial_count,16) entries.
// s_tready is high only in the idle cycle between items. The result sits in
// an output register, and a new word is taken only once the last result is
// in it; if the receiver stalls, the block finishes the next item and then
// waits in its done state until the register frees. Reset clears the table
// (count zero, all entries free), the registers to their defaults and the
// output valid. No clearing pass is needed.
module variable_partition_allocator_unit import vpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // request_size[15:0], release_base[31:16]
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // granted_base[15:0]
	output logic [1:0]  m_tuser,  // status[1:0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	// configuration
	logic [1:0]  fit_q;
	logic        cmp_q;
	logic [4:0]  icnt_q;
	logic [12:0] isz_q;

	// table
	logic [AddrBits-1:0] base_q [MaxEntries];
	logic [SizeW-1:0]    size_q [MaxEntries];
	logic [MaxEntries-1:0] busy_q;
	logic [AddrBits-1:0] base_d [MaxEntries];
	logic [SizeW-1:0]    size_d [MaxEntries];
	logic [MaxEntries-1:0] busy_d;
	logic [CntW-1:0] count_q, count_d;
	logic [IdxW-1:0] nfs_q, nfs_d;

	// sequencer
	state_t state_q, state_d;
	logic [1:0]  act_q;
	logic [15:0] req_q, rel_q;
	logic [CntW-1:0] idx_q, idx_d, w_q, w_d, n_q, n_d, lim_q, lim_d;
	logic [IdxW-1:0] pick_q, pick_d;
	logic found_q, found_d;
	logic [SizeW-1:0] acc_q, acc_d, tot_q, tot_d, hold_q, hold_d, cand_q, cand_d;
	logic [1:0]  rs_q, rs_d;
	logic [15:0] rb_q, rb_d;

	// the single table read port
	logic [AddrBits-1:0] rd_base;
	logic [SizeW-1:0]    rd_size;
	logic                rd_busy;
	assign rd_base = base_q[idx_q[IdxW-1:0]];
	assign rd_size = size_q[idx_q[IdxW-1:0]];
	assign rd_busy = busy_q[idx_q[IdxW-1:0]];

	logic fit_ok, last, better;
	logic [SizeW:0] reb_end;
	assign fit_ok  = !rd_busy && (rd_size >= {1'b0, req_q});
	assign last    = (n_q + 1'b1) == count_q;
	assign reb_end = {1'b0, acc_q} + {{(SizeW-12){1'b0}}, isz_q};
	assign better  = !found_q || ((fit_q == FIT_BEST) ? (rd_size < cand_q)
		: (rd_size > cand_q));

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		base_d = base_q; size_d = size_q; busy_d = busy_q;
		count_d = count_q; nfs_d = nfs_q;
		idx_d = idx_q; w_d = w_q; n_d = n_q; lim_d = lim_q;
		pick_d = pick_q; found_d = found_q;
		acc_d = acc_q; tot_d = tot_q; hold_d = hold_q; cand_d = cand_q;
		rs_d = rs_q; rb_d = rb_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					idx_d = '0; w_d = '0; acc_d = '0; tot_d = '0;
					rs_d = ST_DONE; rb_d = '0;
					priority if (s_tuser == ACT_ALLOC) begin
						state_d = cmp_q ? S_CMP : S_SINIT;
					end else if (s_tuser == ACT_RELEASE) begin
						if (count_q == '0) begin
							rs_d = ST_BAD_BASE; state_d = S_DONE;
						end else state_d = S_RSCAN;
					end else if (s_tuser == ACT_REBUILD) begin
						busy_d = '0; count_d = '0; nfs_d = '0;
						if (isz_q == '0) lim_d = '0;
						else if (icnt_q > CntW'(MaxEntries)) lim_d = CntW'(MaxEntries);
						else lim_d = icnt_q[CntW-1:0];
						state_d = S_REB;
					end else state_d = S_DONE;
				end
			end
			S_REB: begin
				if (idx_q == lim_q || reb_end > (SizeW+1)'(1 << AddrBits)) begin
					state_d = S_DONE;
				end else begin
					base_d[idx_q[IdxW-1:0]] = acc_q[AddrBits-1:0];
					size_d[idx_q[IdxW-1:0]] = {{(SizeW-13){1'b0}}, isz_q};
					count_d = count_q + 1'b1;
					acc_d = reb_end[SizeW-1:0];
					idx_d = idx_q + 1'b1;
				end
			end
			S_CMP: begin
				if (idx_q == count_q) begin
					state_d = S_CMPF;
				end else begin
					if (rd_busy) begin
						base_d[w_q[IdxW-1:0]] = acc_q[AddrBits-1:0];
						size_d[w_q[IdxW-1:0]] = rd_size;
						busy_d[w_q[IdxW-1:0]] = 1'b1;
						acc_d = acc_q + rd_size;
						w_d = w_q + 1'b1;
					end else tot_d = tot_q + rd_size;
					idx_d = idx_q + 1'b1;
				end
			end
			S_CMPF: begin
				for (int k = 0; k < MaxEntries; k++)
					if (CntW'(k) >= w_q) busy_d[k] = 1'b0;
				count_d = w_q;
				if (tot_q != '0 && w_q < CntW'(MaxEntries)) begin
					base_d[w_q[IdxW-1:0]] = acc_q[AddrBits-1:0];
					size_d[w_q[IdxW-1:0]] = tot_q;
					count_d = w_q + 1'b1;
				end
				state_d = S_SINIT;
			end
			S_SINIT: begin
				if (req_q == '0 || count_q == '0) begin
					rs_d = ST_NO_FIT; state_d = S_DONE;
				end else begin
					idx_d = (fit_q == FIT_NEXT && {1'b0, nfs_q} < count_q) ?
						{1'b0, nfs_q} : '0;
					n_d = '0; found_d = 1'b0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if ((fit_q == FIT_FIRST || fit_q == FIT_NEXT) && fit_ok) begin
					pick_d = idx_q[IdxW-1:0]; state_d = S_SPLIT;
				end else begin
					if ((fit_q == FIT_BEST || fit_q == FIT_WORST) && fit_ok && better) begin
						pick_d = idx_q[IdxW-1:0]; cand_d = rd_size; found_d = 1'b1;
					end
					if (last) begin
						if (found_d) begin
							idx_d = {1'b0, pick_d}; state_d = S_SPLIT;
						end else begin
							rs_d = ST_NO_FIT; state_d = S_DONE;
						end
					end else begin
						n_d = n_q + 1'b1;
						idx_d = ((idx_q + 1'b1) == count_q) ? '0 : idx_q + 1'b1;
					end
				end
			end
			S_SPLIT: begin
				state_d = S_DONE;
				if (rd_size != {1'b0, req_q} && count_q >= CntW'(MaxEntries)) begin
					rs_d = ST_FULL;
				end else begin
					if (rd_size != {1'b0, req_q}) begin
						for (int k = MaxEntries-1; k > 0; k--)
							if (CntW'(k) > idx_q + 1'b1) begin
								base_d[k] = base_q[k-1]; size_d[k] = size_q[k-1];
								busy_d[k] = busy_q[k-1];
							end
						base_d[pick_q + 1'b1] = rd_base + req_q;
						size_d[pick_q + 1'b1] = rd_size - {1'b0, req_q};
						busy_d[pick_q + 1'b1] = 1'b0;
						size_d[pick_q] = {1'b0, req_q};
						count_d = count_q + 1'b1;
					end
					busy_d[pick_q] = 1'b1;
					if (fit_q == FIT_NEXT) nfs_d = pick_q;
					rb_d = rd_base;
				end
			end
			S_RSCAN: begin
				if (rd_busy && rd_base == rel_q) begin
					pick_d = idx_q[IdxW-1:0]; state_d = S_R1;
				end else if ((idx_q + 1'b1) == count_q) begin
					rs_d = ST_BAD_BASE; state_d = S_DONE;
				end else idx_d = idx_q + 1'b1;
			end
			S_R1: begin
				hold_d = rd_size;
				busy_d[pick_q] = 1'b0;
				idx_d = idx_q + 1'b1;
				state_d = S_R2;
			end
			S_R2: begin
				// merge with the free entry above
				if (idx_q < count_q && !rd_busy) begin
					hold_d = hold_q + rd_size;
					size_d[pick_q] = hold_d;
					for (int k = 0; k < MaxEntries-1; k++)
						if (CntW'(k) >= idx_q) begin
							base_d[k] = base_q[k+1]; size_d[k] = size_q[k+1];
							busy_d[k] = busy_q[k+1];
						end
					busy_d[MaxEntries-1] = 1'b0;
					count_d = count_q - 1'b1;
				end
				if (pick_q == '0) state_d = S_DONE;
				else begin
					idx_d = {1'b0, pick_q} - 1'b1; state_d = S_R3;
				end
			end
			S_R3: begin
				// merge into the free entry below
				if (!rd_busy) begin
					size_d[idx_q[IdxW-1:0]] = rd_size + hold_q;
					for (int k = 0; k < MaxEntries-1; k++)
						if (k >= int'(pick_q)) begin
							base_d[k] = base_q[k+1]; size_d[k] = size_q[k+1];
							busy_d[k] = busy_q[k+1];
						end
					busy_d[MaxEntries-1] = 1'b0;
					count_d = count_q - 1'b1;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_tvalid || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= '0; count_q <= '0; nfs_q <= '0;
			fit_q <= FIT_FIRST; cmp_q <= 1'b0; icnt_q <= 5'd1; isz_q <= 13'd4096;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q <= busy_d; count_q <= count_d; nfs_q <= nfs_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FIT_MODE: fit_q  <= cfg_data[1:0];
					REG_COMPACT:  cmp_q  <= cfg_data[0];
					REG_INIT_CNT: icnt_q <= cfg_data[4:0];
					REG_INIT_SZ:  isz_q  <= cfg_data;
				endcase
			end
			if (state_q == S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d; size_q <= size_d;
		idx_q <= idx_d; w_q <= w_d; n_q <= n_d; lim_q <= lim_d;
		pick_q <= pick_d; found_q <= found_d;
		acc_q <= acc_d; tot_q <= tot_d; hold_q <= hold_d; cand_q <= cand_d;
		rs_q <= rs_d; rb_q <= rb_d;
		if (state_q == S_IDLE && s_tvalid) begin
			act_q <= s_tuser; req_q <= s_tdata[15:0]; rel_q <= s_tdata[31:16];
		end
		if (state_q == S_DONE && (!m_tvalid || m_tready)) begin
			m_tuser <= (act_q == ACT_ALLOC || act_q == ACT_RELEASE) ? rs_q : ST_DONE;
			m_tdata <= rb_q;
		end
	end

`include "variable_partition_allocator_unit_assert.svh"
	`VPA_ALWAYS(a_count_max, count_q <= CntW'(MaxEntries), "entry count above table depth")
	`VPA_ALWAYS(a_free_tail, count_q >= CntW'(MaxEntries) || !busy_q[count_q[IdxW-1:0]], "busy tail")
	`VPA_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready while an item is in work")
endmodule

>>> verif/tb_top.sv
module tb_top import vpa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// word formats as seen on the ports
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] req_size;
		logic [15:0] rel_base;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] base;
	} rsp_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	variable_partition_allocator_unit i_dut (.*);

	// predictor copy of configuration and table
	logic [1:0]  pm_fit;
	logic        pm_compact;
	logic [4:0]  pm_icount;
	logic [12:0] pm_isize;
	logic [16:0] tab_base [MaxEntries];
	logic [16:0] tab_size [MaxEntries];
	logic        tab_busy [MaxEntries];
	int          tab_cnt;
	int          nf_start;

	req_word_t   pending_q[$];
	rsp_word_t   expected_q[$];
	int          err_cnt;
	int          snd_idle_pct;
	int          rcv_idle_pct;
	int          hold_cycles;

	// ready as seen at the last rising edge, so the driver knows the handshake
	logic s_tready_q;
	always @(posedge clk) s_tready_q <= s_tready;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[variable_partition_allocator_unit] ERROR");
		$finish;
	end

	task automatic tab_remove(input int i);
		for (int k = i; k + 1 < tab_cnt; k++) begin
			tab_base[k] = tab_base[k+1];
			tab_size[k] = tab_size[k+1];
			tab_busy[k] = tab_busy[k+1];
		end
		tab_cnt--;
		tab_busy[tab_cnt] = 1'b0;
	endtask

	task automatic tab_compact();
		int          w;
		logic [16:0] addr;
		logic [16:0] free_sum;
		w = 0;
		addr = '0;
		free_sum = '0;
		for (int i = 0; i < tab_cnt; i++) begin
			if (tab_busy[i]) begin
				tab_base[w] = {1'b0, addr[15:0]};
				tab_size[w] = tab_size[i];
				tab_busy[w] = 1'b1;
				addr += tab_size[i];
				w++;
			end else begin
				free_sum += tab_size[i];
			end
		end
		if (free_sum != 0 && w < MaxEntries) begin
			tab_base[w] = {1'b0, addr[15:0]};
			tab_size[w] = free_sum;
			tab_busy[w] = 1'b0;
			w++;
		end
		for (int i = w; i < MaxEntries; i++) tab_busy[i] = 1'b0;
		tab_cnt = w;
	endtask

	task automatic predict_alloc(input logic [15:0] req, output rsp_word_t r);
		int  pick;
		int  k;
		int  st;
		bit  found;
		r = '0;
		pick = 0;
		found = 0;
		if (pm_compact) tab_compact();
		if (req == 0 || tab_cnt == 0) begin
			r.status = ST_NO_FIT;
			return;
		end
		if (pm_fit == FIT_NEXT) begin
			st = (nf_start < tab_cnt) ? nf_start : 0;
			for (int i = 0; i < tab_cnt && !found; i++) begin
				k = (st + i) % tab_cnt;
				if (!tab_busy[k] && tab_size[k] >= req) begin
					pick = k;
					found = 1;
				end
			end
		end else begin
			for (int i = 0; i < tab_cnt; i++) begin
				if (tab_busy[i] || tab_size[i] < req) continue;
				if (!found) begin
					pick = i;
					found = 1;
					if (pm_fit == FIT_FIRST) break;
				end else if (pm_fit == FIT_BEST && tab_size[i] < tab_size[pick]) begin
					pick = i;
				end else if (pm_fit == FIT_WORST && tab_size[i] > tab_size[pick]) begin
					pick = i;
				end
			end
		end
		if (!found) begin
			r.status = ST_NO_FIT;
			return;
		end
		if (tab_size[pick] != req) begin
			if (tab_cnt >= MaxEntries) begin
				r.status = ST_FULL;
				return;
			end
			for (int j = tab_cnt; j > pick + 1; j--) begin
				tab_base[j] = tab_base[j-1];
				tab_size[j] = tab_size[j-1];
				tab_busy[j] = tab_busy[j-1];
			end
			tab_base[pick+1] = {1'b0, 16'(tab_base[pick] + req)};
			tab_size[pick+1] = tab_size[pick] - req;
			tab_busy[pick+1] = 1'b0;
			tab_cnt++;
			tab_size[pick] = {1'b0, req};
		end
		tab_busy[pick] = 1'b1;
		if (pm_fit == FIT_NEXT) nf_start = pick;
		r.status = ST_DONE;
		r.base = tab_base[pick][15:0];
	endtask

	// one expected result per input word
	task automatic predict_word(input req_word_t w, output rsp_word_t r);
		int          i;
		int          n;
		logic [16:0] addr;
		r = '0;
		case (w.action)
			ACT_ALLOC: begin
				predict_alloc(w.req_size, r);
			end
			ACT_RELEASE: begin
				for (i = 0; i < tab_cnt; i++)
					if (tab_busy[i] && tab_base[i][15:0] == w.rel_base) break;
				if (i >= tab_cnt) begin
					r.status = ST_BAD_BASE;
				end else begin
					tab_busy[i] = 1'b0;
					if (i + 1 < tab_cnt && !tab_busy[i+1]) begin
						tab_size[i] += tab_size[i+1];
						tab_remove(i + 1);
					end
					if (i > 0 && !tab_busy[i-1]) begin
						tab_size[i-1] += tab_size[i];
						tab_remove(i);
					end
				end
			end
			ACT_REBUILD: begin
				for (int j = 0; j < MaxEntries; j++) tab_busy[j] = 1'b0;
				tab_cnt = 0;
				nf_start = 0;
				n = (pm_icount > MaxEntries) ? MaxEntries : pm_icount;
				if (pm_isize == 0) n = 0;
				addr = '0;
				for (int j = 0; j < n; j++) begin
					if (addr + pm_isize > 17'h10000) break;
					tab_base[j] = addr;
					tab_size[j] = {4'd0, pm_isize};
					tab_busy[j] = 1'b0;
					addr += pm_isize;
					tab_cnt++;
				end
			end
			default: ;
		endcase
	endtask

	// driver: takes words from the pending queue, predicts on acceptance
	always @(negedge clk) begin
		rsp_word_t r;
		if (arst_n) begin
			if (s_tvalid && s_tready_q) begin
				predict_word(pending_q.pop_front(), r);
				expected_q.insert(expected_q.size(), r);
			end
			if (pending_q.size() != 0 && (s_tvalid && !s_tready_q ||
					$urandom_range(99) >= snd_idle_pct)) begin
				s_tvalid <= 1'b1;
				s_tuser  <= pending_q[0].action;
				s_tdata  <= {pending_q[0].rel_base, pending_q[0].req_size};
			end else begin
				s_tvalid <= 1'b0;
				s_tdata  <= $urandom;
			end
		end
	end

	// receiver ready: random idling, or a long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_word_t got;
		rsp_word_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata};
			if (expected_q.size() == 0) begin
				$error("unexpected result word status=%0d base=%0h", got.status, got.base);
				err_cnt++;
			end else begin
				exp_w = expected_q.pop_front();
				if (got.status !== exp_w.status) begin
					$error("status: expected %0d, actual %0d", exp_w.status, got.status);
					err_cnt++;
				end
				if (got.base !== exp_w.base) begin
					$error("granted_base: expected %0h, actual %0h", exp_w.base, got.base);
					err_cnt++;
				end
			end
		end
	end

	function automatic req_word_t mk_word(input logic [1:0] a, input logic [15:0] sz,
			input logic [15:0] rb);
		req_word_t w;
		w.action = a;
		w.req_size = sz;
		w.rel_base = rb;
		return w;
	endfunction

	// queue one word for the driver
	task automatic add_word(input req_word_t w);
		pending_q.insert(pending_q.size(), w);
	endtask

	// wait for all results, then let the block settle before a register write
	task automatic drain();
		while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_FIT_MODE: pm_fit = val[1:0];
			REG_COMPACT:  pm_compact = val[0];
			REG_INIT_CNT: pm_icount = val[4:0];
			default:      pm_isize = val;
		endcase
	endtask

	// random allocation size, mostly small, now and then wide
	function automatic logic [15:0] rnd_size();
		case ($urandom_range(9))
			0:       return 16'($urandom);
			1:       return 16'($urandom_range(8191));
			default: return 16'($urandom_range(1, 600));
		endcase
	endfunction

	// one phase: rebuild then a mix of allocs, releases of likely and random bases, rebuilds and unknown actions
	task automatic rnd_phase(input int n);
		logic [15:0] bases[$];
		logic [15:0] b;
		int          sel;
		add_word(mk_word(ACT_REBUILD, 16'($urandom), 16'($urandom)));
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 50) begin
				add_word(mk_word(ACT_ALLOC, rnd_size(), 16'($urandom)));
			end else if (sel < 85 && bases.size() != 0) begin
				b = bases[$urandom_range(bases.size() - 1)];
				add_word(mk_word(ACT_RELEASE, 16'($urandom), b));
			end else if (sel < 92) begin
				add_word(mk_word(ACT_RELEASE, 16'($urandom), 16'($urandom)));
			end else if (sel < 96) begin
				add_word(mk_word(ACT_REBUILD, 16'($urandom), 16'($urandom)));
			end else begin
				add_word(mk_word(2'd3, 16'($urandom), 16'($urandom)));
			end
			// track likely bases: multiples of 16 below 1024
			if (bases.size() < 40)
				bases.insert(bases.size(), 16'($urandom_range(0, 63) * 16));
		end
	endtask

	initial begin
		err_cnt      = 0;
		snd_idle_pct = 22;
		rcv_idle_pct = 54;
		hold_cycles  = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		pm_fit = FIT_FIRST;
		pm_compact = 1'b0;
		pm_icount = 5'd1;
		pm_isize = 13'd4096;
		tab_cnt = 0;
		nf_start = 0;
		for (int i = 0; i < MaxEntries; i++) begin
			tab_busy[i] = 1'b0;
			tab_base[i] = '0;
			tab_size[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, zero size, unknown action, full table, extremes
		add_word(mk_word(ACT_ALLOC, 16'd1, 16'd0));
		add_word(mk_word(ACT_RELEASE, 16'd0, 16'd0));
		add_word(mk_word(2'd3, 16'hFFFF, 16'hFFFF));
		add_word(mk_word(ACT_REBUILD, 16'd0, 16'd0));
		add_word(mk_word(ACT_ALLOC, 16'd0, 16'd0));
		add_word(mk_word(ACT_ALLOC, 16'hFFFF, 16'd0));
		add_word(mk_word(ACT_ALLOC, 16'd4096, 16'd0));
		add_word(mk_word(ACT_RELEASE, 16'd0, 16'hFFFF));
		add_word(mk_word(ACT_RELEASE, 16'd0, 16'd0));
		for (int i = 0; i < 16; i++)
			add_word(mk_word(ACT_ALLOC, 16'd1, 16'd0));
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_cycles = 400;
		rnd_phase(30);
		drain();

		// settings sweep, extremes included
		for (int ph = 0; ph < 16; ph++) begin
			if (ph == 8) begin
				snd_idle_pct = 54;
				rcv_idle_pct = 22;
			end
			if (ph == 12) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			write_reg(REG_FIT_MODE, 13'(ph % 4));
			write_reg(REG_COMPACT, 13'((ph / 4) % 2));
			case (ph % 5)
				0: write_reg(REG_INIT_CNT, 13'd16);
				1: write_reg(REG_INIT_CNT, 13'd31);
				2: write_reg(REG_INIT_CNT, 13'd0);
				default: write_reg(REG_INIT_CNT, 13'($urandom_range(1, 16)));
			endcase
			case (ph % 3)
				0: write_reg(REG_INIT_SZ, 13'h1FFF);
				1: write_reg(REG_INIT_SZ, 13'($urandom_range(1, 8191)));
				default: write_reg(REG_INIT_SZ, (ph == 5) ? 13'd0 : 13'd256);
			endcase
			rnd_phase(80);
			drain();
		end

		if (err_cnt == 0 && expected_q.size() == 0) begin
			$display("[variable_partition_allocator_unit] OK");
		end else begin
			$display("[variable_partition_allocator_unit] ERROR");
		end
		$finish;
	end
endmodule
